@@ sv/move_toward_target_step_macros.svh @@
`ifndef MOVE_TOWARD_TARGET_STEP_MACROS_SVH
`define MOVE_TOWARD_TARGET_STEP_MACROS_SVH

// same-cycle implication
`define MTT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mtt_pkg.sv @@
package mtt_pkg;
  localparam int COORD_WIDTH_D = 32;
  localparam int FRAC_BITS_D   = 16;
  localparam int SPEED_W       = 31;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 2'd1;
endpackage

@@ sv/mtt_in_if.sv @@
interface mtt_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic signed [W-1:0] goal_x;
  logic signed [W-1:0] goal_y;

  modport source (output valid, pos_x, pos_y, goal_x, goal_y, input ready);
  modport sink   (input valid, pos_x, pos_y, goal_x, goal_y, output ready);
endinterface

@@ sv/mtt_out_if.sv @@
interface mtt_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_x;
  logic signed [W-1:0] new_y;
  logic                moved;
  logic                saturated;

  modport source (output valid, new_x, new_y, moved, saturated, input ready);
  modport sink   (input valid, new_x, new_y, moved, saturated, output ready);
endinterface

@@ sv/mtt_cfg_if.sv @@
interface mtt_cfg_if;
  import mtt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPEED_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mtt_isqrt.sv @@
module mtt_isqrt #(
  parameter int RW = 33,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_v,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);
  localparam int TW = RW + 3;

  logic [RW-1:0]                v_r;
  logic [RW-1:0][2*RW-1:0]      rad_r;
  logic [RW-1:0][TW-1:0]        rem_r;
  logic [RW-1:0][RW-1:0]        root_r;
  logic [RW-1:0][SW-1:0]        side_r;

  logic [RW-1:0]                p_v;
  logic [RW-1:0][2*RW-1:0]      p_rad;
  logic [RW-1:0][TW-1:0]        p_rem;
  logic [RW-1:0][RW-1:0]        p_root;
  logic [RW-1:0][SW-1:0]        p_side;

  genvar k;
  for (k = 0; k < RW; k++) begin : g_st
    logic [TW-1:0] t;
    logic [TW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_v[k]    = in_v;
      assign p_rad[k]  = in_rad;
      assign p_rem[k]  = '0;
      assign p_root[k] = '0;
      assign p_side[k] = in_side;
    end else begin : g_next
      assign p_v[k]    = v_r[k-1];
      assign p_rad[k]  = rad_r[k-1];
      assign p_rem[k]  = rem_r[k-1];
      assign p_root[k] = root_r[k-1];
      assign p_side[k] = side_r[k-1];
    end

    assign t     = {p_rem[k][TW-3:0], p_rad[k][2*RW-1 -: 2]};
    assign trial = TW'({p_root[k], 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {p_rad[k][2*RW-3:0], 2'b00};
        rem_r[k]  <= ge ? (t - trial) : t;
        root_r[k] <= {p_root[k][RW-2:0], ge};
        side_r[k] <= p_side[k];
      end
    end
  end

  assign out_v    = v_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];
endmodule

@@ sv/mtt_div.sv @@
module mtt_div #(
  parameter int DW = 33,
  parameter int NW = 63,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [1:0][NW-1:0]  in_num,
  input  logic [DW-1:0]       in_den,
  input  logic [SW-1:0]       in_side,
  output logic                out_v,
  output logic [1:0][QW-1:0]  out_q,
  output logic [SW-1:0]       out_side
);
  logic [QW-1:0]                  v_r;
  logic [QW-1:0][1:0][DW-1:0]     rem_r;
  logic [QW-1:0][1:0][QW-1:0]     low_r;
  logic [QW-1:0][1:0][QW-1:0]     q_r;
  logic [QW-1:0][DW-1:0]          den_r;
  logic [QW-1:0][SW-1:0]          side_r;

  logic [QW-1:0]                  p_v;
  logic [QW-1:0][1:0][DW-1:0]     p_rem;
  logic [QW-1:0][1:0][QW-1:0]     p_low;
  logic [QW-1:0][1:0][QW-1:0]     p_q;
  logic [QW-1:0][DW-1:0]          p_den;
  logic [QW-1:0][SW-1:0]          p_side;

  genvar k, l;
  for (k = 0; k < QW; k++) begin : g_st
    if (k == 0) begin : g_first
      assign p_v[k]    = in_v;
      assign p_den[k]  = in_den;
      assign p_side[k] = in_side;
      for (l = 0; l < 2; l++) begin : g_ln
        assign p_rem[k][l] = DW'(in_num[l][NW-1:QW]);
        assign p_low[k][l] = in_num[l][QW-1:0];
        assign p_q[k][l]   = '0;
      end
    end else begin : g_next
      assign p_v[k]    = v_r[k-1];
      assign p_den[k]  = den_r[k-1];
      assign p_side[k] = side_r[k-1];
      assign p_rem[k]  = rem_r[k-1];
      assign p_low[k]  = low_r[k-1];
      assign p_q[k]    = q_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= p_den[k];
        side_r[k] <= p_side[k];
      end
    end

    for (l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;

      assign t    = {p_rem[k][l], p_low[k][l][QW-1]};
      assign diff = t - {1'b0, p_den[k]};
      assign ge   = (t >= {1'b0, p_den[k]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? diff[DW-1:0] : t[DW-1:0];
          low_r[k][l] <= {p_low[k][l][QW-2:0], 1'b0};
          q_r[k][l]   <= {p_q[k][l][QW-2:0], ge};
        end
      end
    end
  end

  assign out_v    = v_r[QW-1];
  assign out_q    = q_r[QW-1];
  assign out_side = side_r[QW-1];
endmodule

@@ sv/move_toward_target_step.sv @@
// Moves a 2-D point one constant-length step toward a goal. The length of
// goal - pos is the exact integer square root of dx^2 + dy^2; when it exceeds
// stop_threshold each coordinate moves by floor(step_speed * |d| / length)
// toward the goal, with the sum clipped to the coordinate range. Fully
// pipelined: one item per cycle unless the output stalls. The root has
// COORD_WIDTH + 1 one-bit-per-stage stages and the divider 31 stages.
// The whole pipeline holds while a result waits in the output register.
// Configuration writes are always ready.
module move_toward_target_step #(
  parameter int COORD_WIDTH = mtt_pkg::COORD_WIDTH_D,
  parameter int FRAC_BITS   = mtt_pkg::FRAC_BITS_D
) (
  input logic       clk,
  input logic       rst_n,
  mtt_in_if.sink    in_ch,
  mtt_out_if.source out_ch,
  mtt_cfg_if.sink   cfg_ch
);
  import mtt_pkg::*;

`include "move_toward_target_step_macros.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int LW    = CW + 1;
  localparam int H     = (CW + 1) / 2;
  localparam int HW    = CW - H;
  localparam int NW    = SPEED_W + CW;
  localparam int CMPW  = (LW > SPEED_W) ? LW : SPEED_W;
  localparam int SUMW  = ((CW > SPEED_W) ? CW : SPEED_W) + 2;
  localparam int SQ_SW = 4 * CW + 2;
  localparam int DV_SW = 2 * CW + 3;

  localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(64'd1 << FRAC_BITS);
  localparam logic [SPEED_W-1:0] THR_RST   = SPEED_W'((64'd1 << FRAC_BITS) / 100);

  logic [SPEED_W-1:0] speed_r;
  logic [SPEED_W-1:0] thr_r;
  logic               en;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RST;
      thr_r   <= THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STEP_SPEED: speed_r <= cfg_ch.data;
        REG_STOP_THR:   thr_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic out_v_r;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: difference, sign and magnitude
  logic [CW:0]           dx_c, dy_c, ndx_c, ndy_c;
  logic                  a_v_r;
  logic [CW-1:0]         a_px_r, a_py_r;
  logic [1:0]            a_s_r;
  logic [1:0][CW-1:0]    a_ax_r;

  assign dx_c  = {in_ch.goal_x[CW-1], in_ch.goal_x} - {in_ch.pos_x[CW-1], in_ch.pos_x};
  assign dy_c  = {in_ch.goal_y[CW-1], in_ch.goal_y} - {in_ch.pos_y[CW-1], in_ch.pos_y};
  assign ndx_c = -dx_c;
  assign ndy_c = -dy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r    <= in_ch.pos_x;
      a_py_r    <= in_ch.pos_y;
      a_s_r     <= {dy_c[CW], dx_c[CW]};
      a_ax_r[0] <= dx_c[CW] ? ndx_c[CW-1:0] : dx_c[CW-1:0];
      a_ax_r[1] <= dy_c[CW] ? ndy_c[CW-1:0] : dy_c[CW-1:0];
    end
  end

  // stage B: partial products of the squares
  logic                      b_v_r;
  logic [CW-1:0]             b_px_r, b_py_r;
  logic [1:0]                b_s_r;
  logic [1:0][CW-1:0]        b_ax_r;
  logic [1:0][2*HW-1:0]      b_hh_r;
  logic [1:0][HW+H-1:0]      b_hl_r;
  logic [1:0][2*H-1:0]       b_ll_r;

  // stage C: squares
  logic                      c_v_r;
  logic [CW-1:0]             c_px_r, c_py_r;
  logic [1:0]                c_s_r;
  logic [1:0][CW-1:0]        c_ax_r;
  logic [1:0][2*CW-1:0]      c_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_px_r <= a_px_r;
      b_py_r <= a_py_r;
      b_s_r  <= a_s_r;
      b_ax_r <= a_ax_r;
      c_px_r <= b_px_r;
      c_py_r <= b_py_r;
      c_s_r  <= b_s_r;
      c_ax_r <= b_ax_r;
    end
  end

  genvar g;
  for (g = 0; g < 2; g++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        b_hh_r[g] <= a_ax_r[g][CW-1:H] * a_ax_r[g][CW-1:H];
        b_hl_r[g] <= a_ax_r[g][CW-1:H] * a_ax_r[g][H-1:0];
        b_ll_r[g] <= a_ax_r[g][H-1:0] * a_ax_r[g][H-1:0];
        c_sq_r[g] <= {b_hh_r[g], {(2*H){1'b0}}}
                   + (2*CW)'({b_hl_r[g], {(H+1){1'b0}}})
                   + (2*CW)'(b_ll_r[g]);
      end
    end
  end

  // square root
  logic [2*LW-1:0]  rad_c;
  logic             sq_v;
  logic [LW-1:0]    sq_len;
  logic [SQ_SW-1:0] sq_side;

  assign rad_c = (2*LW)'(c_sq_r[0]) + (2*LW)'(c_sq_r[1]);

  mtt_isqrt #(.RW(LW), .SW(SQ_SW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (c_v_r),
    .in_rad   (rad_c),
    .in_side  ({c_px_r, c_py_r, c_s_r, c_ax_r[1], c_ax_r[0]}),
    .out_v    (sq_v),
    .out_root (sq_len),
    .out_side (sq_side)
  );

  // stage E: threshold and step numerator partial products
  logic [CW-1:0]      sq_px, sq_py;
  logic [1:0]         sq_s;
  logic [1:0][CW-1:0] sq_ax;

  assign {sq_px, sq_py, sq_s, sq_ax} = sq_side;

  logic                         e_v_r;
  logic                         e_mv_r;
  logic [CW-1:0]                e_px_r, e_py_r;
  logic [1:0]                   e_s_r;
  logic [LW-1:0]                e_len_r;
  logic [1:0][SPEED_W+H-1:0]    e_pl_r;
  logic [1:0][SPEED_W+HW-1:0]   e_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_mv_r  <= (CMPW'(sq_len) > CMPW'(thr_r));
      e_px_r  <= sq_px;
      e_py_r  <= sq_py;
      e_s_r   <= sq_s;
      e_len_r <= sq_len;
    end
  end

  logic [1:0][NW-1:0] num_c;

  for (g = 0; g < 2; g++) begin : g_num
    always_ff @(posedge clk) begin
      if (en) begin
        e_pl_r[g] <= speed_r * sq_ax[g][H-1:0];
        e_ph_r[g] <= speed_r * sq_ax[g][CW-1:H];
      end
    end
    assign num_c[g] = NW'({e_ph_r[g], {H{1'b0}}}) + NW'(e_pl_r[g]);
  end

  // division by length
  logic               dv_v;
  logic [1:0][SPEED_W-1:0] dv_q;
  logic [DV_SW-1:0]   dv_side;

  mtt_div #(.DW(LW), .NW(NW), .QW(SPEED_W), .SW(DV_SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (e_v_r),
    .in_num   (num_c),
    .in_den   (e_len_r),
    .in_side  ({e_px_r, e_py_r, e_s_r, e_mv_r}),
    .out_v    (dv_v),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // output: apply step, clip
  logic [1:0][CW-1:0] dv_p;
  logic [1:0]         dv_s;
  logic               dv_mv;

  assign {dv_p[0], dv_p[1], dv_s[1], dv_s[0], dv_mv} = dv_side;

  localparam logic signed [SUMW-1:0] HI_C = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] LO_C = ~HI_C;

  logic [1:0][CW-1:0] res_c;
  logic [1:0]         clip_c;

  for (g = 0; g < 2; g++) begin : g_out
    logic signed [SUMW-1:0] pe, qe, sm;
    assign pe = {{(SUMW-CW){dv_p[g][CW-1]}}, dv_p[g]};
    assign qe = {{(SUMW-SPEED_W){1'b0}}, dv_q[g]};
    assign sm = dv_s[g] ? (pe - qe) : (pe + qe);

    always_comb begin
      clip_c[g] = 1'b0;
      res_c[g]  = dv_p[g];
      if (dv_mv) begin
        if (sm > HI_C) begin
          res_c[g]  = HI_C[CW-1:0];
          clip_c[g] = 1'b1;
        end else if (sm < LO_C) begin
          res_c[g]  = LO_C[CW-1:0];
          clip_c[g] = 1'b1;
        end else begin
          res_c[g]  = sm[CW-1:0];
        end
      end
    end
  end

  logic [CW-1:0] out_x_r, out_y_r;
  logic          out_mv_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= res_c[0];
      out_y_r   <= res_c[1];
      out_mv_r  <= dv_mv;
      out_sat_r <= |clip_c;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.new_x     = out_x_r;
  assign out_ch.new_y     = out_y_r;
  assign out_ch.moved     = out_mv_r;
  assign out_ch.saturated = out_sat_r;

  `MTT_ASSERT_IMP(a_stall_blocks, out_ch.valid && !out_ch.ready, !in_ch.ready, "input transfer during output stall")
  `MTT_ASSERT_IMP(a_sat_needs_move, out_ch.valid && !out_ch.moved, !out_ch.saturated, "clip without move")
  `MTT_ASSERT_IMP(a_sat_bound, out_ch.valid && out_ch.saturated, (out_ch.new_x == HI_C[CW-1:0]) || (out_ch.new_x == LO_C[CW-1:0]) || (out_ch.new_y == HI_C[CW-1:0]) || (out_ch.new_y == LO_C[CW-1:0]), "saturated without bound value")
  `MTT_ASSERT_NXT(a_cfg_thr, cfg_ch.valid && cfg_ch.index == REG_STOP_THR, thr_r == $past(cfg_ch.data), "threshold write lost")
endmodule
